@@ hw/rtl/unit_scan_and_command_sequencer_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef UNIT_SCAN_AND_COMMAND_SEQUENCER_ASSERT_SVH
`define UNIT_SCAN_AND_COMMAND_SEQUENCER_ASSERT_SVH

// Checked on every rising edge while the block is out of reset.
`define USCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define USCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/uscs_pkg.sv @@
`timescale 1ns / 1ps
package uscs_pkg;

  localparam int MAP_W = 10;

  localparam logic [1:0] FUNC_TASK = 2'd0;
  localparam logic [1:0] FUNC_SCAN = 2'd1;
  localparam logic [1:0] FUNC_SEND = 2'd2;

  localparam logic [2:0] RR_LOST     = 3'd2;
  localparam logic [2:0] RR_RECEIVED = 3'd4;

  localparam logic [1:0] RUN_IDLE = 2'd0;
  localparam logic [1:0] RUN_SCAN = 2'd1;
  localparam logic [1:0] RUN_SEND = 2'd2;

  localparam logic [1:0] CAUSE_RESPONSE = 2'd0;
  localparam logic [1:0] CAUSE_LOST     = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT  = 2'd2;

  localparam logic [1:0] REG_SELECTED = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_RETRIES  = 2'd2;

  localparam logic [3:0]  SELECTED_RESET = 4'd0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd200;
  localparam logic [3:0]  RETRIES_RESET  = 4'd3;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_SCAN = 3'b010,
    MODE_SEND = 3'b100
  } mode_e;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_START   = 6'b000010,
    PH_REQUEST = 6'b000100,
    PH_WAIT    = 6'b001000,
    PH_LOST    = 6'b010000,
    PH_FOUND   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] radio_result;
    logic [7:0] ms_passed;
    logic       message_kind;
    logic [1:0] command_code;
  } item_t;

  typedef struct packed {
    logic [3:0]  selected_device;
    logic [15:0] timeout_ms;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic             send_valid;
    logic [3:0]       send_device;
    logic             send_kind;
    logic [1:0]       send_command;
    logic             busy_rejected;
    logic [1:0]       run_mode;
    logic             scan_finished;
    logic [MAP_W-1:0] active_map;
    logic             command_finished;
    logic [1:0]       finish_cause;
  } res_t;

endpackage

@@ hw/rtl/uscs_engine.sv @@
`timescale 1ns / 1ps
module uscs_engine #(
  parameter int DEVICE_COUNT = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  uscs_pkg::item_t item_i,
  input  uscs_pkg::cfg_t  cfg_i,
  output uscs_pkg::res_t  res_o
);

  localparam int IW = $clog2(DEVICE_COUNT + 1);

  uscs_pkg::mode_e         mode_q, mode_d;
  uscs_pkg::phase_e        phase_q, phase_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic [3:0]              retry_q, retry_d;
  logic [DEVICE_COUNT-1:0] act_q, act_d;
  logic [15:0]             elapsed_q, elapsed_d;

  logic [16:0]             el_sum;
  logic [15:0]             el_add;
  logic                    timed_out;
  logic [3:0]              limit;
  logic [IW-1:0]           idx_t;
  uscs_pkg::res_t          res_c;
  logic [uscs_pkg::MAP_W-1:0] map_w;

  always_comb begin
    el_sum    = {1'b0, elapsed_q} + 17'(item_i.ms_passed);
    el_add    = el_sum[16] ? 16'hFFFF : el_sum[15:0];
    timed_out = el_add > cfg_i.timeout_ms;
    limit     = (cfg_i.max_retries == 4'd0) ? 4'd1 : cfg_i.max_retries;

    mode_d    = mode_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    retry_d   = retry_q;
    act_d     = act_q;
    elapsed_d = el_add;
    idx_t     = idx_q;
    res_c     = '0;

    case (item_i.func)
      uscs_pkg::FUNC_SCAN: begin
        if (mode_q != uscs_pkg::MODE_IDLE) begin
          res_c.busy_rejected = 1'b1;
        end else begin
          mode_d  = uscs_pkg::MODE_SCAN;
          phase_d = uscs_pkg::PH_START;
        end
      end
      uscs_pkg::FUNC_SEND: begin
        if (mode_q != uscs_pkg::MODE_IDLE) begin
          res_c.busy_rejected = 1'b1;
        end else begin
          res_c.send_valid   = 1'b1;
          res_c.send_device  = cfg_i.selected_device;
          res_c.send_kind    = item_i.message_kind;
          res_c.send_command = item_i.message_kind ? item_i.command_code : 2'd0;
          mode_d             = uscs_pkg::MODE_SEND;
          elapsed_d          = '0;
        end
      end
      uscs_pkg::FUNC_TASK: begin
        if (mode_q == uscs_pkg::MODE_SCAN) begin
          case (phase_q)
            uscs_pkg::PH_START: begin
              idx_d   = '0;
              phase_d = uscs_pkg::PH_REQUEST;
            end
            uscs_pkg::PH_REQUEST: begin
              if (retry_q >= limit) begin
                for (int b = 0; b < DEVICE_COUNT; b++) begin
                  if (idx_q == IW'(b)) begin
                    act_d[b] = 1'b0;
                  end
                end
                idx_t   = idx_q + IW'(1);
                retry_d = '0;
              end
              idx_d = idx_t;
              if (idx_t >= IW'(DEVICE_COUNT)) begin
                phase_d             = uscs_pkg::PH_IDLE;
                mode_d              = uscs_pkg::MODE_IDLE;
                res_c.scan_finished = 1'b1;
              end else begin
                res_c.send_valid  = 1'b1;
                res_c.send_device = 4'(idx_t);
                phase_d           = uscs_pkg::PH_WAIT;
                elapsed_d         = '0;
              end
            end
            uscs_pkg::PH_WAIT: begin
              if (item_i.radio_result == uscs_pkg::RR_RECEIVED) begin
                phase_d = uscs_pkg::PH_FOUND;
              end else if (item_i.radio_result == uscs_pkg::RR_LOST) begin
                phase_d = uscs_pkg::PH_LOST;
              end
              if (timed_out) begin
                phase_d = uscs_pkg::PH_LOST;
              end
            end
            uscs_pkg::PH_LOST: begin
              retry_d = retry_q + 4'd1;
              phase_d = uscs_pkg::PH_REQUEST;
            end
            uscs_pkg::PH_FOUND: begin
              for (int b = 0; b < DEVICE_COUNT; b++) begin
                if (idx_q == IW'(b)) begin
                  act_d[b] = 1'b1;
                end
              end
              idx_d   = idx_q + IW'(1);
              retry_d = '0;
              phase_d = uscs_pkg::PH_REQUEST;
            end
            default: begin
            end
          endcase
        end else if (mode_q == uscs_pkg::MODE_SEND) begin
          if (item_i.radio_result == uscs_pkg::RR_RECEIVED) begin
            mode_d                 = uscs_pkg::MODE_IDLE;
            res_c.command_finished = 1'b1;
            res_c.finish_cause     = uscs_pkg::CAUSE_RESPONSE;
          end else if (item_i.radio_result == uscs_pkg::RR_LOST) begin
            mode_d                 = uscs_pkg::MODE_IDLE;
            res_c.command_finished = 1'b1;
            res_c.finish_cause     = uscs_pkg::CAUSE_LOST;
          end else if (timed_out) begin
            mode_d                 = uscs_pkg::MODE_IDLE;
            res_c.command_finished = 1'b1;
            res_c.finish_cause     = uscs_pkg::CAUSE_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase

    case (mode_d)
      uscs_pkg::MODE_SCAN: res_c.run_mode = uscs_pkg::RUN_SCAN;
      uscs_pkg::MODE_SEND: res_c.run_mode = uscs_pkg::RUN_SEND;
      default:             res_c.run_mode = uscs_pkg::RUN_IDLE;
    endcase
  end

  for (genvar b = 0; b < uscs_pkg::MAP_W; b++) begin : g_map
    if (b < DEVICE_COUNT) begin : g_on
      assign map_w[b] = act_d[b];
    end else begin : g_off
      assign map_w[b] = 1'b0;
    end
  end

  always_comb begin
    res_o            = res_c;
    res_o.active_map = map_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= uscs_pkg::MODE_IDLE;
      phase_q   <= uscs_pkg::PH_IDLE;
      idx_q     <= '0;
      retry_q   <= '0;
      act_q     <= '0;
      elapsed_q <= '0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      retry_q   <= retry_d;
      act_q     <= act_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

@@ hw/rtl/unit_scan_and_command_sequencer.sv @@
`timescale 1ns / 1ps
// Poll sequencer for radio units.
// Requests arrive on the input channel (in_valid_i / in_ready_o) with fields
// func_i, radio_result_i, ms_passed_i, message_kind_i and command_code_i.
// Every request yields exactly one result on the output channel
// (out_valid_o / out_ready_i): the message to hand to the radio, the mode
// after the request, scan and command completion flags and the active map.
// Registers selected_device, timeout_ms and max_retries sit at byte addresses
// 0, 4 and 8 of the APB port; pready is always high and writes take effect
// at the access cycle. Write them only while no request is in flight.
// A request is registered on acceptance and its result is registered in the
// result register once that register is free. One request per cycle is
// accepted unless the receiver stalls, set by the single state update step.
// Reset clears the mode, scan state, active map and timer, and restores the
// register defaults. When the receiver stalls, the result register holds its
// value and the input register fills, after which in_ready_o drops.
module unit_scan_and_command_sequencer #(
  parameter int DEVICE_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  radio_result_i,
  input  logic [7:0]  ms_passed_i,
  input  logic        message_kind_i,
  input  logic [1:0]  command_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_valid_o,
  output logic [3:0]  send_device_o,
  output logic        send_kind_o,
  output logic [1:0]  send_command_o,
  output logic        busy_rejected_o,
  output logic [1:0]  run_mode_o,
  output logic        scan_finished_o,
  output logic [9:0]  active_map_o,
  output logic        command_finished_o,
  output logic [1:0]  finish_cause_o
);

  uscs_pkg::cfg_t  cfg_q;
  uscs_pkg::item_t item_q;
  uscs_pkg::res_t  res_c;
  uscs_pkg::res_t  res_q;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic            s1_adv;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.selected_device <= uscs_pkg::SELECTED_RESET;
      cfg_q.timeout_ms      <= uscs_pkg::TIMEOUT_RESET;
      cfg_q.max_retries     <= uscs_pkg::RETRIES_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        uscs_pkg::REG_SELECTED: begin
          if ({1'b0, pwdata[3:0]} < 5'(DEVICE_COUNT)) begin
            cfg_q.selected_device <= pwdata[3:0];
          end
        end
        uscs_pkg::REG_TIMEOUT: cfg_q.timeout_ms  <= pwdata[15:0];
        uscs_pkg::REG_RETRIES: cfg_q.max_retries <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uscs_pkg::REG_SELECTED: prdata = {28'd0, cfg_q.selected_device};
      uscs_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout_ms};
      uscs_pkg::REG_RETRIES:  prdata = {28'd0, cfg_q.max_retries};
      default:                prdata = '0;
    endcase
  end

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func         <= func_i;
      item_q.radio_result <= radio_result_i;
      item_q.ms_passed    <= ms_passed_i;
      item_q.message_kind <= message_kind_i;
      item_q.command_code <= command_code_i;
    end
    if (s1_adv) begin
      res_q <= res_c;
    end
  end

  uscs_engine #(
    .DEVICE_COUNT(DEVICE_COUNT)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(s1_adv),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .res_o    (res_c)
  );

  assign out_valid_o        = out_valid_q;
  assign send_valid_o       = res_q.send_valid;
  assign send_device_o      = res_q.send_device;
  assign send_kind_o        = res_q.send_kind;
  assign send_command_o     = res_q.send_command;
  assign busy_rejected_o    = res_q.busy_rejected;
  assign run_mode_o         = res_q.run_mode;
  assign scan_finished_o    = res_q.scan_finished;
  assign active_map_o       = res_q.active_map;
  assign command_finished_o = res_q.command_finished;
  assign finish_cause_o     = res_q.finish_cause;

endmodule

@@ hw/rtl/uscs_checker.sv @@
`timescale 1ns / 1ps
`include "unit_scan_and_command_sequencer_assert.svh"
module uscs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       send_valid_o,
  input logic [3:0] send_device_o,
  input logic [1:0] run_mode_o,
  input logic       scan_finished_o,
  input logic       command_finished_o,
  input logic [1:0] finish_cause_o
);

  // A stalled result stays offered with the same send device and run mode.
  `USCS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(send_device_o) && $stable(run_mode_o), "stalled result changed")

  // A message handed to the radio always leaves the block busy.
  `USCS_ASSERT(a_send_busy, out_valid_o && send_valid_o |-> run_mode_o != uscs_pkg::RUN_IDLE, "message sent while idle")

  // A finished scan or command returns to idle and sends nothing.
  `USCS_ASSERT(a_done_idle, out_valid_o && (scan_finished_o || command_finished_o) |-> run_mode_o == uscs_pkg::RUN_IDLE && !send_valid_o, "completion without idle")

  // The finish cause is one of the defined causes.
  `USCS_ASSERT(a_cause_ok, out_valid_o && command_finished_o |-> finish_cause_o == uscs_pkg::CAUSE_RESPONSE || finish_cause_o == uscs_pkg::CAUSE_LOST || finish_cause_o == uscs_pkg::CAUSE_TIMEOUT, "bad finish cause")

  // The register port never inserts wait states.
  `USCS_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind unit_scan_and_command_sequencer uscs_checker u_uscs_checker (.*);

@@ test/unit_scan_and_command_sequencer_tb.sv @@
`timescale 1ns / 1ps
module unit_scan_and_command_sequencer_tb;
  import uscs_pkg::*;

  localparam int DEVICES = 10;
  localparam int CHUNK = 97;
  localparam int CHUNKS = 9;
  localparam int unsigned CYCLE_LIMIT = 300000;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] RR_NONE = 3'd0;
  localparam logic [2:0] RR_BUSY = 3'd1;
  localparam logic [2:0] RR_SENT = 3'd3;
  localparam logic [2:0] RR_RESERVED_LO = 3'd5;
  localparam logic [2:0] RR_RESERVED_HI = 3'd7;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SHUTTER = 1'b1;

  localparam logic [1:0] CMD_S1_UP = 2'd0;
  localparam logic [1:0] CMD_S1_DOWN = 2'd1;
  localparam logic [1:0] CMD_S2_UP = 2'd2;
  localparam logic [1:0] CMD_S2_DOWN = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = '0;
  logic [2:0] radio_result_i = '0;
  logic [7:0] ms_passed_i = '0;
  logic message_kind_i = 1'b0;
  logic [1:0] command_code_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic send_valid_o;
  logic [3:0] send_device_o;
  logic send_kind_o;
  logic [1:0] send_command_o;
  logic busy_rejected_o;
  logic [1:0] run_mode_o;
  logic scan_finished_o;
  logic [9:0] active_map_o;
  logic command_finished_o;
  logic [1:0] finish_cause_o;

  unit_scan_and_command_sequencer #(
    .DEVICE_COUNT(DEVICES)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .func_i(func_i),
    .radio_result_i(radio_result_i),
    .ms_passed_i(ms_passed_i),
    .message_kind_i(message_kind_i),
    .command_code_i(command_code_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .send_valid_o(send_valid_o),
    .send_device_o(send_device_o),
    .send_kind_o(send_kind_o),
    .send_command_o(send_command_o),
    .busy_rejected_o(busy_rejected_o),
    .run_mode_o(run_mode_o),
    .scan_finished_o(scan_finished_o),
    .active_map_o(active_map_o),
    .command_finished_o(command_finished_o),
    .finish_cause_o(finish_cause_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int tx_idle_pct = 34;
  int rx_idle_pct = 75;
  int fail_count = 0;
  int unsigned cycle_count = 0;

  res_t sequencer_results_q[$];
  res_t observed;
  res_t due;

  mode_e mode_q;
  phase_e phase_q;
  logic [4:0] scan_idx;
  logic [3:0] retry_cnt;
  logic [9:0] active_units;
  logic [15:0] elapsed;
  logic [3:0] sel_dev;
  logic [15:0] timeout_lim;
  logic [3:0] retry_lim;

  function automatic void reset_sequencer_model();
    mode_q = MODE_IDLE;
    phase_q = PH_IDLE;
    scan_idx = '0;
    retry_cnt = '0;
    active_units = '0;
    elapsed = '0;
    sel_dev = SELECTED_RESET;
    timeout_lim = TIMEOUT_RESET;
    retry_lim = RETRIES_RESET;
  endfunction

  function automatic res_t sequencer_advance(item_t it);
    res_t r;
    logic [16:0] sum;
    logic [3:0] limit;
    r = '0;
    sum = {1'b0, elapsed} + it.ms_passed;
    elapsed = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
    limit = (retry_lim == 4'd0) ? 4'd1 : retry_lim;
    case (it.func)
      FUNC_SCAN: begin
        if (mode_q != MODE_IDLE) begin
          r.busy_rejected = 1'b1;
        end else begin
          mode_q = MODE_SCAN;
          phase_q = PH_START;
        end
      end
      FUNC_SEND: begin
        if (mode_q != MODE_IDLE) begin
          r.busy_rejected = 1'b1;
        end else begin
          r.send_valid = 1'b1;
          r.send_device = sel_dev;
          r.send_kind = it.message_kind;
          r.send_command = (it.message_kind == KIND_SHUTTER) ? it.command_code : '0;
          mode_q = MODE_SEND;
          elapsed = '0;
        end
      end
      FUNC_TASK: begin
        if (mode_q == MODE_SCAN) begin
          case (phase_q)
            PH_START: begin
              scan_idx = '0;
              phase_q = PH_REQUEST;
            end
            PH_REQUEST: begin
              if (retry_cnt >= limit) begin
                if (scan_idx < DEVICES) active_units[scan_idx] = 1'b0;
                scan_idx = scan_idx + 5'd1;
                retry_cnt = '0;
              end
              if (scan_idx >= DEVICES) begin
                phase_q = PH_IDLE;
                mode_q = MODE_IDLE;
                r.scan_finished = 1'b1;
              end else begin
                r.send_valid = 1'b1;
                r.send_device = scan_idx[3:0];
                phase_q = PH_WAIT;
                elapsed = '0;
              end
            end
            PH_WAIT: begin
              if (it.radio_result == RR_RECEIVED) phase_q = PH_FOUND;
              else if (it.radio_result == RR_LOST) phase_q = PH_LOST;
              if (elapsed > timeout_lim) phase_q = PH_LOST;
            end
            PH_LOST: begin
              retry_cnt = retry_cnt + 4'd1;
              phase_q = PH_REQUEST;
            end
            PH_FOUND: begin
              if (scan_idx < DEVICES) active_units[scan_idx] = 1'b1;
              scan_idx = scan_idx + 5'd1;
              retry_cnt = '0;
              phase_q = PH_REQUEST;
            end
            default: begin
            end
          endcase
        end else if (mode_q == MODE_SEND) begin
          if (it.radio_result == RR_RECEIVED) begin
            mode_q = MODE_IDLE;
            r.command_finished = 1'b1;
            r.finish_cause = CAUSE_RESPONSE;
          end else if (it.radio_result == RR_LOST) begin
            mode_q = MODE_IDLE;
            r.command_finished = 1'b1;
            r.finish_cause = CAUSE_LOST;
          end else if (elapsed > timeout_lim) begin
            mode_q = MODE_IDLE;
            r.command_finished = 1'b1;
            r.finish_cause = CAUSE_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
    case (mode_q)
      MODE_SCAN: r.run_mode = RUN_SCAN;
      MODE_SEND: r.run_mode = RUN_SEND;
      default: r.run_mode = RUN_IDLE;
    endcase
    r.active_map = active_units;
    return r;
  endfunction

  function automatic item_t make_request(logic [1:0] f, logic [2:0] rr, logic [7:0] ms,
                                         logic kind, logic [1:0] code);
    item_t it;
    it.func = f;
    it.radio_result = rr;
    it.ms_passed = ms;
    it.message_kind = kind;
    it.command_code = code;
    return it;
  endfunction

  function automatic logic [7:0] random_ms();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 8'($urandom_range(0, 15));
    if (pick < 90) return 8'($urandom_range(0, 255));
    return 8'd255;
  endfunction

  function automatic item_t next_random_request();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.func = FUNC_TASK;
    it.radio_result = 3'($urandom_range(0, 7));
    it.ms_passed = random_ms();
    it.message_kind = 1'($urandom_range(0, 1));
    it.command_code = 2'($urandom_range(0, 3));
    if (pick < 8) begin
      it.func = 2'($urandom_range(0, 3));
    end else if (mode_q == MODE_IDLE) begin
      it.func = (pick < 54) ? FUNC_SCAN : FUNC_SEND;
    end else if (pick < 13) begin
      it.func = (pick < 11) ? FUNC_SCAN : FUNC_SEND;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) it.radio_result = RR_RECEIVED;
      else if (pick < 70) it.radio_result = RR_LOST;
    end
    return it;
  endfunction

  task automatic send_request(item_t it);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    radio_result_i <= it.radio_result;
    ms_passed_i <= it.ms_passed;
    message_kind_i <= it.message_kind;
    command_code_i <= it.command_code;
    do @(posedge clk_i); while (!in_ready_o);
    sequencer_results_q.push_back(sequencer_advance(it));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sequencer_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SELECTED: if (value[3:0] < DEVICES) sel_dev = value[3:0];
      REG_TIMEOUT: timeout_lim = value[15:0];
      REG_RETRIES: retry_lim = value[3:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic randomize_registers();
    int pick;
    logic [15:0] lim;
    pick = $urandom_range(0, 3);
    case (pick)
      0: lim = 16'($urandom_range(0, 50));
      1: lim = 16'($urandom_range(100, 600));
      2: lim = 16'hFFFF;
      default: lim = 16'($urandom());
    endcase
    write_register(REG_SELECTED, $urandom());
    write_register(REG_TIMEOUT, {16'($urandom()), lim});
    write_register(REG_RETRIES, $urandom());
  endtask

  task automatic test_command_send();
    send_request(make_request(FUNC_SEND, RR_NONE, 8'd255, KIND_SHUTTER, CMD_S2_DOWN));
    send_request(make_request(FUNC_SEND, RR_NONE, 8'd0, KIND_SHUTTER, CMD_S1_DOWN));
    send_request(make_request(FUNC_SCAN, RR_RECEIVED, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_RECEIVED, 8'd255, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_SEND, RR_NONE, 8'd0, KIND_STATUS, CMD_S2_UP));
    send_request(make_request(FUNC_TASK, RR_RESERVED_LO, 8'd100, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_LOST, 8'd200, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_SEND, RR_NONE, 8'd0, KIND_SHUTTER, CMD_S1_DOWN));
    send_request(make_request(FUNC_TASK, RR_BUSY, 8'd201, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_UNUSED, RR_SENT, 8'd255, KIND_SHUTTER, CMD_S2_DOWN));
  endtask

  task automatic test_register_edges();
    drain_results();
    write_register(REG_SELECTED, DEVICES);
    write_register(REG_SELECTED, 32'hFFFF_FFF9);
    write_register(REG_TIMEOUT, 32'h0000_FFFF);
    write_register(REG_RETRIES, 32'h0000_0000);
    send_request(make_request(FUNC_SEND, RR_NONE, 8'd0, KIND_SHUTTER, CMD_S2_UP));
    send_request(make_request(FUNC_TASK, RR_RESERVED_HI, 8'd255, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_RESERVED_LO, 8'd255, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_LOST, 8'd255, KIND_STATUS, CMD_S1_UP));
  endtask

  // During a scan, a response that arrives together with a timeout counts as a lost request.
  task automatic test_scan_corner_cases();
    drain_results();
    write_register(REG_TIMEOUT, 32'd10);
    send_request(make_request(FUNC_SCAN, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_SCAN, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_SEND, RR_NONE, 8'd0, KIND_SHUTTER, CMD_S2_DOWN));
    send_request(make_request(FUNC_TASK, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_RECEIVED, 8'd11, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_RECEIVED, 8'd10, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_NONE, 8'd0, KIND_STATUS, CMD_S1_UP));
    send_request(make_request(FUNC_TASK, RR_LOST, 8'd0, KIND_STATUS, CMD_S1_UP));
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == CHUNKS / 3) begin
        tx_idle_pct = 75;
        rx_idle_pct = 34;
      end else if (chunk == 2 * CHUNKS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain_results();
      if (chunk == 0) begin
        write_register(REG_SELECTED, 32'd0);
        write_register(REG_TIMEOUT, 32'd0);
        write_register(REG_RETRIES, 32'd15);
      end else begin
        randomize_registers();
      end
      for (int n = 0; n < CHUNK; n++) send_request(next_random_request());
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed = {send_valid_o, send_device_o, send_kind_o, send_command_o, busy_rejected_o,
                  run_mode_o, scan_finished_o, active_map_o, command_finished_o,
                  finish_cause_o};
      if (sequencer_results_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: result with no pending request, expected none, actual %h",
                 $time, observed);
      end else begin
        due = sequencer_results_q.pop_front();
        compare_field("send_valid", due.send_valid, observed.send_valid);
        compare_field("send_device", due.send_device, observed.send_device);
        compare_field("send_kind", due.send_kind, observed.send_kind);
        compare_field("send_command", due.send_command, observed.send_command);
        compare_field("busy_rejected", due.busy_rejected, observed.busy_rejected);
        compare_field("run_mode", due.run_mode, observed.run_mode);
        compare_field("scan_finished", due.scan_finished, observed.scan_finished);
        compare_field("active_map", due.active_map, observed.active_map);
        compare_field("command_finished", due.command_finished, observed.command_finished);
        compare_field("finish_cause", due.finish_cause, observed.finish_cause);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reset_sequencer_model();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_command_send();
    test_register_edges();
    test_scan_corner_cases();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
